@@ rtl/tssl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tssl_pkg
// Shared types, constants and the 2^-f table for the three-shape slew limiter.
// ----------------------------------------------------------------------------
package tssl_pkg;

  // Interpolated 2^-f table
  localparam int EXP_TABLE_BITS = 8;
  localparam int TABLE_LEN      = (1 << EXP_TABLE_BITS) + 1;
  localparam int ROM_SHIFT      = 30 - EXP_TABLE_BITS;
  localparam int PROD_W         = 32 + ROM_SHIFT;

  // Fixed-point constants
  localparam logic [30:0] TENTH_Q34 = 31'd1717986918;
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;

  // Serial divider: 65-bit dividend, one quotient bit per cycle
  localparam int DIV_LEN = 65;
  localparam int CNT_W   = $clog2(DIV_LEN + 1);

  // Configuration port
  localparam int ADDR_W = 4;
  localparam logic [1:0] REG_TICK_PERIOD    = 2'd0;
  localparam logic [1:0] REG_GATE_PATCHED   = 2'd1;
  localparam logic [1:0] REG_GATE_THRESHOLD = 2'd2;

  localparam logic [31:0] TICK_RESET   = 32'd89478;
  localparam logic [23:0] THRESH_RESET = 24'd104858;

  typedef struct packed {
    logic [31:0]        tick_period;
    logic               gate_patched;
    logic signed [23:0] gate_threshold;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_ESCALE,
    OP_FOLLOW,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_LIN_UPD,
    OP_COEF_MUL,
    OP_COEF_FIN,
    OP_MF_LO,
    OP_MF_HI,
    OP_MF_APPLY
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [1:0] shape;
    logic       stage;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic e_le0;
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,
    ST_CHECK,
    ST_DIV,
    ST_LIN,
    ST_COEF_MUL,
    ST_COEF_FIN,
    ST_MF_LO,
    ST_MF_HI,
    ST_MF_APPLY,
    ST_NEXT,
    ST_DONE
  } ctrl_state_e;

  localparam logic [1:0] SHAPE_LINEAR = 2'd0;
  localparam logic [1:0] SHAPE_EXPO   = 2'd1;
  localparam logic [1:0] SHAPE_SCURVE = 2'd2;

  typedef logic [31:0] rom_t [TABLE_LEN];

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] b;
    x = v;
    r = '0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic rom_t build_pow2_rom();
    rom_t        rom;
    logic [63:0] root [EXP_TABLE_BITS];
    logic [63:0] v;
    logic [63:0] p;
    v = 64'd1 << 30;
    for (int j = EXP_TABLE_BITS - 1; j >= 0; j--) begin
      v = isqrt64(v << 31);
      root[j] = v;
    end
    for (int k = 0; k < (1 << EXP_TABLE_BITS); k++) begin
      p = 64'd1 << 31;
      for (int j = 0; j < EXP_TABLE_BITS; j++) begin
        if (((k >> j) & 1) == 1) p = (p * root[j] + (64'd1 << 30)) >> 31;
      end
      rom[k] = p[31:0];
    end
    rom[1 << EXP_TABLE_BITS] = 32'd1 << 30;
    return rom;
  endfunction

  localparam rom_t POW2_ROM = build_pow2_rom();

endpackage
`default_nettype wire

@@ rtl/tssl_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tssl_regs
// APB-style configuration registers.
// ----------------------------------------------------------------------------
module tssl_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tssl_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output tssl_pkg::cfg_t               cfg_o
);

  tssl_pkg::cfg_t cfg_q, cfg_d;
  logic [1:0]     idx;
  logic           wr_en;

  assign idx    = paddr[3:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        tssl_pkg::REG_TICK_PERIOD:    cfg_d.tick_period    = pwdata;
        tssl_pkg::REG_GATE_PATCHED:   cfg_d.gate_patched   = pwdata[0];
        tssl_pkg::REG_GATE_THRESHOLD: cfg_d.gate_threshold = pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      tssl_pkg::REG_TICK_PERIOD:    prdata = cfg_q.tick_period;
      tssl_pkg::REG_GATE_PATCHED:   prdata = {31'd0, cfg_q.gate_patched};
      tssl_pkg::REG_GATE_THRESHOLD: prdata = {8'd0, cfg_q.gate_threshold};
      default:                      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tick_period    <= tssl_pkg::TICK_RESET;
      cfg_q.gate_patched   <= 1'b0;
      cfg_q.gate_threshold <= tssl_pkg::THRESH_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/tssl_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tssl_ctrl
// Sequencer: walks the three shapes, runs the divider, drives the datapath.
// ----------------------------------------------------------------------------
module tssl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  tssl_pkg::status_t status_i,
  output tssl_pkg::cmd_t    cmd_o
);

  tssl_pkg::ctrl_state_e          state_q, state_d;
  logic [1:0]                     shape_q, shape_d;
  logic                           stage_q, stage_d;
  logic [tssl_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic                           out_valid_q, out_valid_d;
  logic                           out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  // Next state
  always_comb begin
    state_d = state_q;
    shape_d = shape_q;
    stage_d = stage_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      tssl_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = tssl_pkg::ST_SCALE;
          shape_d = tssl_pkg::SHAPE_LINEAR;
          stage_d = 1'b0;
        end
      end
      tssl_pkg::ST_SCALE: state_d = tssl_pkg::ST_CHECK;
      tssl_pkg::ST_CHECK: begin
        cnt_d = '0;
        if (status_i.e_le0) state_d = tssl_pkg::ST_NEXT;
        else state_d = tssl_pkg::ST_DIV;
      end
      tssl_pkg::ST_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == tssl_pkg::CNT_W'(tssl_pkg::DIV_LEN - 1)) begin
          if (shape_q == tssl_pkg::SHAPE_LINEAR) state_d = tssl_pkg::ST_LIN;
          else state_d = tssl_pkg::ST_COEF_MUL;
        end
      end
      tssl_pkg::ST_LIN:      state_d = tssl_pkg::ST_NEXT;
      tssl_pkg::ST_COEF_MUL: state_d = tssl_pkg::ST_COEF_FIN;
      tssl_pkg::ST_COEF_FIN: begin
        state_d = tssl_pkg::ST_MF_LO;
        stage_d = 1'b0;
      end
      tssl_pkg::ST_MF_LO:    state_d = tssl_pkg::ST_MF_HI;
      tssl_pkg::ST_MF_HI:    state_d = tssl_pkg::ST_MF_APPLY;
      tssl_pkg::ST_MF_APPLY: begin
        if (shape_q == tssl_pkg::SHAPE_SCURVE && !stage_q) begin
          stage_d = 1'b1;
          state_d = tssl_pkg::ST_MF_LO;
        end else begin
          state_d = tssl_pkg::ST_NEXT;
        end
      end
      tssl_pkg::ST_NEXT: begin
        stage_d = 1'b0;
        if (shape_q == tssl_pkg::SHAPE_SCURVE) begin
          state_d = tssl_pkg::ST_DONE;
        end else begin
          shape_d = shape_q + 1'b1;
          state_d = tssl_pkg::ST_SCALE;
        end
      end
      tssl_pkg::ST_DONE: begin
        if (out_free) state_d = tssl_pkg::ST_IDLE;
      end
      default: state_d = tssl_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o.op       = tssl_pkg::OP_NONE;
    cmd_o.shape    = shape_q;
    cmd_o.stage    = stage_q;
    cmd_o.out_load = 1'b0;
    in_ready_o     = 1'b0;
    unique case (state_q)
      tssl_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = tssl_pkg::OP_LOAD;
      end
      tssl_pkg::ST_SCALE: cmd_o.op = tssl_pkg::OP_ESCALE;
      tssl_pkg::ST_CHECK: begin
        if (status_i.e_le0) cmd_o.op = tssl_pkg::OP_FOLLOW;
        else cmd_o.op = tssl_pkg::OP_DIV_INIT;
      end
      tssl_pkg::ST_DIV:      cmd_o.op = tssl_pkg::OP_DIV_STEP;
      tssl_pkg::ST_LIN:      cmd_o.op = tssl_pkg::OP_LIN_UPD;
      tssl_pkg::ST_COEF_MUL: cmd_o.op = tssl_pkg::OP_COEF_MUL;
      tssl_pkg::ST_COEF_FIN: cmd_o.op = tssl_pkg::OP_COEF_FIN;
      tssl_pkg::ST_MF_LO:    cmd_o.op = tssl_pkg::OP_MF_LO;
      tssl_pkg::ST_MF_HI:    cmd_o.op = tssl_pkg::OP_MF_HI;
      tssl_pkg::ST_MF_APPLY: cmd_o.op = tssl_pkg::OP_MF_APPLY;
      tssl_pkg::ST_NEXT:     cmd_o.op = tssl_pkg::OP_NONE;
      tssl_pkg::ST_DONE:     cmd_o.out_load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (state_q == tssl_pkg::ST_DONE && out_free) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tssl_pkg::ST_IDLE;
      shape_q     <= tssl_pkg::SHAPE_LINEAR;
      stage_q     <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      shape_q     <= shape_d;
      stage_q     <= stage_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/tssl_dpath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tssl_dpath
// Follower state, slew product, serial divider, coefficient and pole update.
// ----------------------------------------------------------------------------
module tssl_dpath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tssl_pkg::cfg_t     cfg_i,
  input  tssl_pkg::cmd_t     cmd_i,
  output tssl_pkg::status_t  status_o,
  input  logic signed [23:0] sample_in_i,
  input  logic signed [23:0] slew_time_i,
  input  logic signed [23:0] rise_scale_i,
  input  logic signed [23:0] fall_scale_i,
  input  logic signed [23:0] gate_level_i,
  output logic signed [23:0] linear_out_o,
  output logic signed [23:0] expo_out_o,
  output logic signed [23:0] scurve_out_o
);

  localparam int TB = tssl_pkg::EXP_TABLE_BITS;
  localparam int SH = tssl_pkg::ROM_SHIFT;
  localparam int PROD_W_L = tssl_pkg::PROD_W;

  // Follower state (Q3.36)
  logic signed [39:0] lin_q, lin_d, expo_q, expo_d, first_q, first_d, scv_q, scv_d;

  // Item registers
  logic signed [39:0] target_q;
  logic [22:0]        slew_q;
  logic signed [23:0] rise_q, fall_q;
  logic               active_q;
  logic [64:0]        num_lin_q;
  logic [62:0]        num_y_q;
  logic signed [47:0] e_q;

  // Divider
  logic [64:0] dq_q;
  logic [47:0] dr_q;
  logic [47:0] div_t;
  logic        div_ge;

  // Coefficient
  logic [31:0]        hi_q;
  logic [PROD_W_L-1:0] prod_q;
  logic [4:0]         n_q;
  logic               big_q;
  logic [31:0]        a_q;

  // Pole multiply partials
  logic [51:0] plo_q;
  logic [52:0] phi_q;

  logic signed [39:0] level_dir;
  logic signed [23:0] scale_sel;
  logic signed [47:0] e_prod;

  logic [41:0]        lin_step;
  logic signed [40:0] lin_diff;
  logic [40:0]        lin_mag;
  logic [41:0]        lin_sum;

  logic [TB-1:0]      rom_idx;
  logic [31:0]        rom_hi, rom_lo, rom_diff;
  logic [31:0]        interp, g_val;

  logic signed [39:0] mf_src, mf_lvl;
  logic signed [40:0] mf_d;
  logic [40:0]        mf_m;
  logic [20:0]        mf_part;
  logic [52:0]        mf_prod;
  logic [72:0]        mf_sum;
  logic [41:0]        mf_r;
  logic [41:0]        mf_new;

  // Direction against this shape's own output
  always_comb begin
    case (cmd_i.shape)
      tssl_pkg::SHAPE_LINEAR: level_dir = lin_q;
      tssl_pkg::SHAPE_EXPO:   level_dir = expo_q;
      default:                level_dir = scv_q;
    endcase
  end
  assign scale_sel = (target_q >= level_dir) ? rise_q : fall_q;
  assign e_prod    = $signed({1'b0, slew_q}) * scale_sel;
  assign status_o.e_le0 = e_q[47] || (e_q == '0);

  // Restoring divide step
  assign div_t  = {dr_q[46:0], dq_q[64]};
  assign div_ge = div_t >= {1'b0, e_q[46:0]};

  // Linear limiter: cap the step at 2^41
  assign lin_step = (|dq_q[64:41]) ? {1'b1, 41'd0} : dq_q[41:0];
  assign lin_diff = {target_q[39], target_q} - {lin_q[39], lin_q};
  assign lin_mag  = lin_diff[40] ? 41'(-lin_diff) : 41'(lin_diff);
  assign lin_sum  = lin_diff[40] ? ({{2{lin_q[39]}}, lin_q} - lin_step)
                                 : ({{2{lin_q[39]}}, lin_q} + lin_step);

  // Table lookup with interpolation
  assign rom_idx  = dq_q[29 -: TB];
  assign rom_hi   = tssl_pkg::POW2_ROM[{1'b0, rom_idx}];
  assign rom_lo   = tssl_pkg::POW2_ROM[{1'b0, rom_idx} + 1'b1];
  assign rom_diff = (rom_hi >= rom_lo) ? (rom_hi - rom_lo) : '0;
  assign interp   = hi_q - 32'(prod_q >> SH);
  assign g_val    = interp >> n_q;

  // Pole update: distance times coefficient, truncated toward zero
  always_comb begin
    if (cmd_i.stage) begin
      mf_src = first_q;
      mf_lvl = scv_q;
    end else begin
      mf_src = target_q;
      mf_lvl = (cmd_i.shape == tssl_pkg::SHAPE_EXPO) ? expo_q : first_q;
    end
  end
  assign mf_d    = {mf_src[39], mf_src} - {mf_lvl[39], mf_lvl};
  assign mf_m    = mf_d[40] ? 41'(-mf_d) : 41'(mf_d);
  assign mf_part = (cmd_i.op == tssl_pkg::OP_MF_HI) ? mf_m[40:20] : {1'b0, mf_m[19:0]};
  assign mf_prod = mf_part * a_q;
  assign mf_sum  = {phi_q, 20'd0} + {21'd0, plo_q};
  assign mf_r    = mf_sum[72:31];
  assign mf_new  = mf_d[40] ? ({{2{mf_lvl[39]}}, mf_lvl} - mf_r)
                            : ({{2{mf_lvl[39]}}, mf_lvl} + mf_r);

  // Follower next values
  always_comb begin
    lin_d   = lin_q;
    expo_d  = expo_q;
    first_d = first_q;
    scv_d   = scv_q;
    case (cmd_i.op)
      tssl_pkg::OP_FOLLOW: begin
        case (cmd_i.shape)
          tssl_pkg::SHAPE_LINEAR: lin_d = target_q;
          tssl_pkg::SHAPE_EXPO:   expo_d = target_q;
          default: begin
            first_d = target_q;
            scv_d   = target_q;
          end
        endcase
      end
      tssl_pkg::OP_LIN_UPD: begin
        if ({1'b0, lin_mag} <= lin_step) lin_d = target_q;
        else lin_d = lin_sum[39:0];
      end
      tssl_pkg::OP_MF_APPLY: begin
        if (cmd_i.stage) scv_d = mf_new[39:0];
        else if (cmd_i.shape == tssl_pkg::SHAPE_EXPO) expo_d = mf_new[39:0];
        else first_d = mf_new[39:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lin_q   <= '0;
      expo_q  <= '0;
      first_q <= '0;
      scv_q   <= '0;
    end else begin
      lin_q   <= lin_d;
      expo_q  <= expo_d;
      first_q <= first_d;
      scv_q   <= scv_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      tssl_pkg::OP_LOAD: begin
        target_q  <= {sample_in_i, 16'd0};
        slew_q    <= slew_time_i[23] ? '0 : slew_time_i[22:0];
        rise_q    <= rise_scale_i;
        fall_q    <= fall_scale_i;
        active_q  <= !cfg_i.gate_patched || (gate_level_i >= cfg_i.gate_threshold);
        num_lin_q <= {63'(cfg_i.tick_period) * 63'(tssl_pkg::TENTH_Q34), 2'b00};
        num_y_q   <= 63'(cfg_i.tick_period) * 63'(tssl_pkg::LOG2E_Q30);
      end
      tssl_pkg::OP_ESCALE: e_q <= active_q ? e_prod : '0;
      tssl_pkg::OP_DIV_INIT: begin
        dq_q <= (cmd_i.shape == tssl_pkg::SHAPE_LINEAR) ? num_lin_q : {2'b00, num_y_q};
        dr_q <= '0;
      end
      tssl_pkg::OP_DIV_STEP: begin
        dq_q <= {dq_q[63:0], div_ge};
        dr_q <= div_ge ? (div_t - {1'b0, e_q[46:0]}) : div_t;
      end
      tssl_pkg::OP_COEF_MUL: begin
        hi_q   <= rom_hi;
        prod_q <= rom_diff * dq_q[SH-1:0];
        n_q    <= dq_q[34:30];
        big_q  <= |dq_q[64:35];
      end
      tssl_pkg::OP_COEF_FIN: a_q <= big_q ? 32'h8000_0000 : (32'h8000_0000 - g_val);
      tssl_pkg::OP_MF_LO:    plo_q <= mf_prod[51:0];
      tssl_pkg::OP_MF_HI:    phi_q <= mf_prod;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      linear_out_o <= lin_q[39:16];
      expo_out_o   <= expo_q[39:16];
      scurve_out_o <= scv_q[39:16];
    end
  end

endmodule
`default_nettype wire

@@ rtl/three_shape_slew_limiter_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// three_shape_slew_limiter_core
// Linear, exponential and S-curve followers driven by one sample per tick.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one tick: target sample,
//   slew time, rise and fall scales and the gate level. Output channel
//   (out_valid_o/out_ready_i) carries the three follower outputs.
//   in_ready_o is high only while the sequencer is idle; one tick is worked
//   at a time. Each shape first scales its slew product and checks it; when
//   it is not positive the shape follows the target at once; otherwise a
//   65-bit bit-serial divide runs, then the linear step, or coefficient and
//   update with one pole (exponential) or two poles (S-curve).
//   The three shapes take turns on the one shared serial divider.
//   Results sit in an output register: the next tick is accepted while a
//   result waits, and a stalled receiver only holds the sequencer in its last
//   state until the pending result transfers.
//   Reset clears all follower levels to zero, restores the configuration
//   defaults and drops out_valid_o. Configure over the APB port while idle.
// ----------------------------------------------------------------------------
module three_shape_slew_limiter_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tssl_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  // tick input
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [23:0]          sample_in_i,
  input  logic signed [23:0]          slew_time_i,
  input  logic signed [23:0]          rise_scale_i,
  input  logic signed [23:0]          fall_scale_i,
  input  logic signed [23:0]          gate_level_i,
  // results
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [23:0]          linear_out_o,
  output logic signed [23:0]          expo_out_o,
  output logic signed [23:0]          scurve_out_o
);

  tssl_pkg::cfg_t    cfg;
  tssl_pkg::cmd_t    cmd;
  tssl_pkg::status_t status;

  // Register file
  tssl_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Sequencer: shape loop, divider count, output handshake
  tssl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Arithmetic and follower state
  tssl_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cmd_i        (cmd),
    .status_o     (status),
    .sample_in_i  (sample_in_i),
    .slew_time_i  (slew_time_i),
    .rise_scale_i (rise_scale_i),
    .fall_scale_i (fall_scale_i),
    .gate_level_i (gate_level_i),
    .linear_out_o (linear_out_o),
    .expo_out_o   (expo_out_o),
    .scurve_out_o (scurve_out_o)
  );

endmodule
`default_nettype wire

@@ rtl/tssl_sva.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tssl_sva
// Port-level checks for the slew limiter core.
// ----------------------------------------------------------------------------
module tssl_sva (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic signed [23:0]          linear_out_o,
  input logic signed [23:0]          expo_out_o,
  input logic signed [23:0]          scurve_out_o
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(linear_out_o)
      && $stable(expo_out_o) && $stable(scurve_out_o))
    else $error("stalled result changed");

  // One tick at a time: busy right after a transfer in
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after accepting a tick");

  // A new result never appears the cycle after a transfer in
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result too early");

endmodule

bind three_shape_slew_limiter_core tssl_sva u_sva (.*);
`default_nettype wire
